FILE: sv/bgr_pkg.sv
// Shared types and constants for the bitmap glyph row renderer.
// Holds the field widths, the mode codes, the controller states and the
// command and status structs between controller and datapath.
package bgr_pkg;

   // Default geometry of the glyph store and the stride ceiling.
   localparam int GLYPH_ROWS_DEFAULT  = 16;
   localparam int GLYPH_COUNT_DEFAULT = 256;
   localparam int MAX_STRIDE_DEFAULT  = 16384;

   // Fixed field widths of the item and result formats.
   localparam int FONT_ADDR_W   = 12;
   localparam int FONT_BYTE_W   = 8;
   localparam int CHAR_CODE_W   = 8;
   localparam int POS_W         = 14;
   localparam int COLOR_W       = 32;
   localparam int STRIDE_W      = 15;
   localparam int PIXEL_INDEX_W = 29;
   localparam int MASK_W        = 8;

   localparam int REQ_TDATA_W = 88;
   localparam int RSP_TDATA_W = 72;

   localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(1024);

   // Item kinds carried on the request tuser.
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_DRAW = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_ROWS
   } bgr_state_type;

   typedef struct packed {
      logic write_font;
      logic capture;
      logic setup_mul;
      logic setup_add;
      logic issue;
   } bgr_cmd_type;

   typedef struct packed {
      logic fetch_free;
      logic last_row;
   } bgr_status_type;

endpackage

FILE: sv/bgr_ctrl.sv
// Controller state machine of the glyph row renderer.
// Depends on bgr_pkg for the state enum and the command and status structs.
module bgr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic                    req_mode,
   input  bgr_pkg::bgr_status_type status,
   output bgr_pkg::bgr_cmd_type    cmd
);
   import bgr_pkg::*;

   bgr_state_type state_ff;
   bgr_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_mode == MODE_DRAW) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_MUL;
               end else begin
                  cmd.write_font = 1'b1;
               end
            end
         end
         ST_MUL: begin
            cmd.setup_mul = 1'b1;
            state_in      = ST_ADD;
         end
         ST_ADD: begin
            cmd.setup_add = 1'b1;
            state_in      = ST_ROWS;
         end
         ST_ROWS: begin
            if (status.fetch_free) begin
               cmd.issue = 1'b1;
               if (status.last_row) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: sv/bgr_datapath.sv
// Datapath of the glyph row renderer: stride register, glyph store,
// row address generation, one fetch stage and the result register.
// Depends on bgr_pkg for widths and the command and status structs.
module bgr_datapath #(
   parameter int GLYPH_ROWS  = bgr_pkg::GLYPH_ROWS_DEFAULT,
   parameter int GLYPH_COUNT = bgr_pkg::GLYPH_COUNT_DEFAULT,
   parameter int MAX_STRIDE  = bgr_pkg::MAX_STRIDE_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bgr_pkg::bgr_cmd_type                cmd,
   output bgr_pkg::bgr_status_type             status,
   input  logic                                csr_valid,
   input  logic [bgr_pkg::STRIDE_W-1:0]        csr_data,
   input  logic [bgr_pkg::FONT_ADDR_W-1:0]     font_address,
   input  logic [bgr_pkg::FONT_BYTE_W-1:0]     font_byte,
   input  logic [bgr_pkg::CHAR_CODE_W-1:0]     char_code,
   input  logic [bgr_pkg::POS_W-1:0]           glyph_x,
   input  logic [bgr_pkg::POS_W-1:0]           glyph_y,
   input  logic [bgr_pkg::COLOR_W-1:0]         color,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bgr_pkg::PIXEL_INDEX_W-1:0]   pixel_index,
   output logic [bgr_pkg::MASK_W-1:0]          write_mask,
   output logic [bgr_pkg::COLOR_W-1:0]         pixel_value,
   output logic                                last_row
);
   import bgr_pkg::*;

   localparam int DEPTH  = GLYPH_COUNT * GLYPH_ROWS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int ROW_W  = $clog2(GLYPH_ROWS);
   localparam int PY_W   = $clog2((1 << POS_W) + GLYPH_ROWS);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GLYPH_ROWS - 1);

   logic [FONT_BYTE_W-1:0] glyph_mem [DEPTH];

   logic [STRIDE_W-1:0]      stride_ff;
   logic [STRIDE_W-1:0]      eff_stride;
   logic [CHAR_CODE_W-1:0]   code_ff;
   logic [CHAR_CODE_W-1:0]   code_wrapped;
   logic [POS_W-1:0]         gx_ff;
   logic [POS_W-1:0]         gy_ff;
   logic [COLOR_W-1:0]       color_ff;
   logic [ADDR_W-1:0]        glyph_base_ff;
   logic [PIXEL_INDEX_W-1:0] idx_ff;
   logic [PY_W-1:0]          py_ff;
   logic [ROW_W-1:0]         row_ff;
   logic [MASK_W-1:0]        col_ok_ff;
   logic [MASK_W-1:0]        col_ok_in;

   // Fetch stage: glyph byte plus everything needed to form the result.
   logic                     f_valid_ff;
   logic [FONT_BYTE_W-1:0]   f_bits_ff;
   logic [PIXEL_INDEX_W-1:0] f_idx_ff;
   logic                     f_row_ok_ff;
   logic                     f_last_ff;
   logic [COLOR_W-1:0]       f_color_ff;
   logic [MASK_W-1:0]        f_col_ok_ff;

   logic                     rsp_valid_ff;
   logic [PIXEL_INDEX_W-1:0] rsp_idx_ff;
   logic [MASK_W-1:0]        rsp_mask_ff;
   logic [COLOR_W-1:0]       rsp_color_ff;
   logic                     rsp_last_ff;
   logic [MASK_W-1:0]        mask_in;
   logic                     move;

   always_comb begin
      if (32'(stride_ff) > 32'(MAX_STRIDE)) begin
         eff_stride = STRIDE_W'(MAX_STRIDE);
      end else begin
         eff_stride = stride_ff;
      end
   end

   // Codes at or beyond the glyph count wrap; the code is below twice the count.
   assign code_wrapped = (32'(code_ff) >= 32'(GLYPH_COUNT)) ?
                         CHAR_CODE_W'(32'(code_ff) - 32'(GLYPH_COUNT)) : code_ff;

   always_comb begin
      for (int j = 0; j < MASK_W; j++) begin
         col_ok_in[j] = (32'(gx_ff) + 32'(j)) < 32'(eff_stride);
      end
   end

   always_comb begin
      for (int j = 0; j < MASK_W; j++) begin
         mask_in[j] = f_bits_ff[MASK_W-1-j] & f_col_ok_ff[j] & f_row_ok_ff;
      end
   end

   assign move              = f_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign status.fetch_free = !f_valid_ff || move;
   assign status.last_row   = (row_ff == LAST_ROW);

   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff <= STRIDE_RESET;
      end else if (csr_valid) begin
         stride_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_font && (32'(font_address) < 32'(DEPTH))) begin
         glyph_mem[ADDR_W'(font_address)] <= font_byte;
      end
      if (cmd.issue) begin
         f_bits_ff <= glyph_mem[ADDR_W'(glyph_base_ff + ADDR_W'(row_ff))];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         code_ff  <= char_code;
         gx_ff    <= glyph_x;
         gy_ff    <= glyph_y;
         color_ff <= color;
      end
      if (cmd.setup_mul) begin
         idx_ff        <= PIXEL_INDEX_W'(32'(gy_ff) * 32'(eff_stride));
         glyph_base_ff <= ADDR_W'(32'(code_wrapped) * 32'(GLYPH_ROWS));
         py_ff         <= PY_W'(gy_ff);
         col_ok_ff     <= col_ok_in;
      end
      if (cmd.setup_add) begin
         idx_ff <= idx_ff + PIXEL_INDEX_W'(gx_ff);
         row_ff <= '0;
      end
      if (cmd.issue) begin
         f_idx_ff    <= idx_ff;
         f_row_ok_ff <= 32'(py_ff) < 32'(eff_stride);
         f_last_ff   <= status.last_row;
         f_color_ff  <= color_ff;
         f_col_ok_ff <= col_ok_ff;
         idx_ff      <= idx_ff + PIXEL_INDEX_W'(eff_stride);
         py_ff       <= py_ff + PY_W'(1);
         row_ff      <= row_ff + ROW_W'(1);
      end
      if (move) begin
         rsp_idx_ff   <= f_idx_ff;
         rsp_mask_ff  <= mask_in;
         rsp_color_ff <= f_color_ff;
         rsp_last_ff  <= f_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.issue) begin
            f_valid_ff <= 1'b1;
         end else if (move) begin
            f_valid_ff <= 1'b0;
         end
         if (move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign pixel_index = rsp_idx_ff;
   assign write_mask  = rsp_mask_ff;
   assign pixel_value = rsp_color_ff;
   assign last_row    = rsp_last_ff;

endmodule

FILE: sv/bitmap_glyph_row_renderer.sv
// Draw item: accepted, then the setup states (row start multiply, then the
// column offset add), then one glyph row a cycle unless the result side stalls,
// GLYPH_ROWS rows, limited by the single read port of the glyph store. After a
// load the next item can follow at once; after a draw, once the last row issues.
// Reset clears the controller and the result pipeline and sets row_stride to 1024;
// the glyph store is not cleared and must be loaded before it is drawn from.
module bitmap_glyph_row_renderer #(
   parameter int GLYPH_ROWS  = bgr_pkg::GLYPH_ROWS_DEFAULT,
   parameter int GLYPH_COUNT = bgr_pkg::GLYPH_COUNT_DEFAULT,
   parameter int MAX_STRIDE  = bgr_pkg::MAX_STRIDE_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request items.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // Fields from bit 0 up: font_address[11:0], font_byte[19:12],
   // char_code[27:20], glyph_x[41:28], glyph_y[55:42], color[87:56].
   input  logic [bgr_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // Fields: mode[0] (0 loads a font byte, 1 draws a character).
   input  logic                              req_tuser,
   // Result items, one per glyph row.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // Fields from bit 0 up: pixel_index[28:0], write_mask[36:29],
   // pixel_value[68:37], zero fill [71:69].
   output logic [bgr_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast,
   // Configuration: row_stride write.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bgr_pkg::STRIDE_W-1:0]      csr_data
);
   import bgr_pkg::*;

   bgr_cmd_type    cmd;
   bgr_status_type status;

   logic [PIXEL_INDEX_W-1:0] pixel_index;
   logic [MASK_W-1:0]        write_mask;
   logic [COLOR_W-1:0]       pixel_value;

   // The stride register takes a write in any cycle.
   assign csr_ready = 1'b1;

   bgr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   bgr_datapath #(
      .GLYPH_ROWS  (GLYPH_ROWS),
      .GLYPH_COUNT (GLYPH_COUNT),
      .MAX_STRIDE  (MAX_STRIDE)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .csr_valid    (csr_valid),
      .csr_data     (csr_data),
      .font_address (req_tdata[11:0]),
      .font_byte    (req_tdata[19:12]),
      .char_code    (req_tdata[27:20]),
      .glyph_x      (req_tdata[41:28]),
      .glyph_y      (req_tdata[55:42]),
      .color        (req_tdata[87:56]),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .pixel_index  (pixel_index),
      .write_mask   (write_mask),
      .pixel_value  (pixel_value),
      .last_row     (rsp_tlast)
   );

   // Pack the result fields, lowest field first, zero filled to whole bytes.
   assign rsp_tdata = {3'b000, pixel_value, write_mask, pixel_index};

endmodule
